### hw/rtl/trle_pkg.sv
// Shared types and constants for the TGA run-length pixel decoder.
// Used by trle_packet_ctrl, trle_convert and tga_rle_pixel_decoder_top.
`timescale 1ns / 1ps

package trle_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_COMPRESSED      = 2'd0;
  localparam logic [1:0] CFG_BYTES_PER_PIXEL = 2'd1;
  localparam logic [1:0] CFG_PIXEL_MODE      = 2'd2;
  localparam logic [1:0] CFG_ALPHA_BITS      = 2'd3;

  // Pixel conversion modes; the unused code behaves as raw copy
  localparam logic [1:0] MODE_RAW    = 2'd0;
  localparam logic [1:0] MODE_SWAP   = 2'd1;
  localparam logic [1:0] MODE_EXPAND = 2'd2;

  // Reset values of the configuration registers
  localparam logic       RST_COMPRESSED      = 1'b0;
  localparam logic [2:0] RST_BYTES_PER_PIXEL = 3'd3;
  localparam logic [1:0] RST_PIXEL_MODE      = MODE_SWAP;
  localparam logic [3:0] RST_ALPHA_BITS      = 4'd0;

  // Run packet headers at or above this value announce a repeated pixel
  localparam logic [7:0] RUN_HEADER_MIN = 8'd128;
  localparam logic [7:0] RUN_BIAS       = 8'd127;
  localparam logic [7:0] ALPHA_OPAQUE   = 8'd255;

  // Up to four source bytes of one pixel, byte 0 in the low slice
  typedef logic [3:0][7:0] pix_bytes_t;

  // Completion status from the packet controller
  typedef struct packed {
    logic       emit;
    logic [7:0] run;
  } emit_t;

  // One converted pixel
  typedef struct packed {
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;
    logic [7:0] chan3;
    logic [2:0] channel_count;
  } pixel_t;

endpackage

### hw/rtl/trle_packet_ctrl.sv
// Packet and pixel assembly state for the TGA run-length pixel decoder.
// Depends on trle_pkg for the pixel byte and completion types.
`timescale 1ns / 1ps

module trle_packet_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  input  logic               frame_start,
  input  logic               compressed,
  input  logic [2:0]         eff_bpp,
  output trle_pkg::emit_t    status,
  output trle_pkg::pix_bytes_t pix_bytes
);

  logic [7:0] repeat_left_r, repeat_left_nxt;
  logic [7:0] literal_left_r, literal_left_nxt;
  logic [1:0] byte_pos_r, byte_pos_nxt;
  logic       collect_run_r, collect_run_nxt;
  trle_pkg::pix_bytes_t bytes_r, bytes_nxt;

  logic [7:0] rl_cur;
  logic [7:0] ll_cur;
  logic [1:0] pos_cur;
  logic       run_cur;
  logic       do_gather;
  logic       complete;

  // Frame start clears the packet state before the byte is used.
  always_comb begin
    rl_cur  = frame_start ? 8'd0 : repeat_left_r;
    ll_cur  = frame_start ? 8'd0 : literal_left_r;
    pos_cur = frame_start ? 2'd0 : byte_pos_r;
    run_cur = frame_start ? 1'b0 : collect_run_r;
  end

  // Store the byte at the current position; the pixel ends at the last byte.
  always_comb begin
    bytes_nxt          = bytes_r;
    bytes_nxt[pos_cur] = data_byte;
    complete           = ({1'b0, pos_cur} + 3'd1) >= eff_bpp;
  end

  assign pix_bytes = bytes_nxt;

  // Next packet state and completion.
  always_comb begin
    repeat_left_nxt  = rl_cur;
    literal_left_nxt = ll_cur;
    byte_pos_nxt     = pos_cur;
    collect_run_nxt  = run_cur;
    do_gather        = 1'b0;
    status.emit      = 1'b0;
    status.run       = 8'd1;
    if (!compressed) begin
      do_gather   = 1'b1;
      status.emit = complete;
    end else if (!run_cur && (ll_cur == 8'd0)) begin
      // Packet header byte
      byte_pos_nxt = 2'd0;
      if (data_byte >= trle_pkg::RUN_HEADER_MIN) begin
        repeat_left_nxt = data_byte - trle_pkg::RUN_BIAS;
        collect_run_nxt = 1'b1;
      end else begin
        literal_left_nxt = data_byte + 8'd1;
      end
    end else begin
      do_gather = 1'b1;
      if (complete) begin
        status.emit = 1'b1;
        if (run_cur) begin
          status.run      = rl_cur;
          repeat_left_nxt = 8'd0;
          collect_run_nxt = 1'b0;
        end else begin
          literal_left_nxt = ll_cur - 8'd1;
        end
      end
    end
    if (do_gather) begin
      byte_pos_nxt = complete ? 2'd0 : pos_cur + 2'd1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repeat_left_r  <= 8'd0;
      literal_left_r <= 8'd0;
      byte_pos_r     <= 2'd0;
      collect_run_r  <= 1'b0;
    end else if (accept) begin
      repeat_left_r  <= repeat_left_nxt;
      literal_left_r <= literal_left_nxt;
      byte_pos_r     <= byte_pos_nxt;
      collect_run_r  <= collect_run_nxt;
    end
  end

  // Pixel byte store, no reset needed
  always_ff @(posedge clk) begin
    if (accept && do_gather) begin
      bytes_r <= bytes_nxt;
    end
  end

endmodule

### hw/rtl/trle_convert.sv
// Pixel format conversion for the TGA run-length pixel decoder.
// Depends on trle_pkg for the mode codes and pixel types.
`timescale 1ns / 1ps

module trle_convert (
  input  trle_pkg::pix_bytes_t pix_bytes,
  input  logic [2:0]           eff_bpp,
  input  logic [1:0]           pixel_mode,
  input  logic [3:0]           alpha_bits,
  output trle_pkg::pixel_t     pixel
);

  trle_pkg::pix_bytes_t b;
  logic [4:0] red5, green5, blue5;

  // Bytes past the pixel width read as zero.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      b[k] = (3'(k) < eff_bpp) ? pix_bytes[k] : 8'd0;
    end
  end

  // 5-bit fields of the little-endian 16-bit word
  assign red5   = b[1][6:2];
  assign green5 = {b[1][1:0], b[0][7:5]};
  assign blue5  = b[0][4:0];

  always_comb begin
    pixel = '0;
    case (pixel_mode)
      trle_pkg::MODE_SWAP: begin
        pixel.chan0 = b[2];
        pixel.chan1 = b[1];
        pixel.chan2 = b[0];
        if (alpha_bits != 4'd0) begin
          pixel.chan3         = b[3];
          pixel.channel_count = 3'd4;
        end else begin
          pixel.channel_count = 3'd3;
        end
      end
      trle_pkg::MODE_EXPAND: begin
        // Replicate the top bits to fill out eight bits per channel.
        pixel.chan0 = {red5, red5[4:2]};
        pixel.chan1 = {green5, green5[4:2]};
        pixel.chan2 = {blue5, blue5[4:2]};
        if (alpha_bits == 4'd1) begin
          pixel.chan3         = b[1][7] ? 8'd0 : trle_pkg::ALPHA_OPAQUE;
          pixel.channel_count = 3'd4;
        end else begin
          pixel.channel_count = 3'd3;
        end
      end
      default: begin
        pixel.chan0         = b[0];
        pixel.chan1         = b[1];
        pixel.chan2         = b[2];
        pixel.chan3         = b[3];
        pixel.channel_count = eff_bpp;
      end
    endcase
  end

endmodule

### hw/rtl/tga_rle_pixel_decoder_top.sv
// Top level of the TGA run-length pixel decoder: configuration registers,
// packet control, conversion and the result register.
// Depends on trle_pkg, trle_packet_ctrl and trle_convert.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one byte of TGA image data
//   per item, with in_frame_start marking the first byte of a new image.
//   The result channel (out_valid/out_ready) carries one converted pixel and
//   its run count whenever a pixel's last byte has been taken. Packet header
//   bytes and inner pixel bytes give no result.
//   The configuration channel (cfg_valid/cfg_ready) is always ready; write it
//   only while no item is in flight.
// Flow:
//   One byte is accepted per cycle while in_ready is high. A pixel comes
//   from a single result register, in the cycle after its last byte is taken.
// Reset:
//   Synchronous, active low. Packet state is cleared and the registers take
//   compressed=0, bytes_per_pixel=3, pixel_mode=swap, alpha_bits=0.
// Stall:
//   While a result waits with out_ready low, in_ready is low; in_ready is
//   high whenever the result register is empty or being emptied.
`timescale 1ns / 1ps

module tga_rle_pixel_decoder_top (
  input  logic       clk,
  input  logic       rst_n,
  // Configuration write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  // Byte input channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_frame_start,
  // Pixel result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_chan0,
  output logic [7:0] out_chan1,
  output logic [7:0] out_chan2,
  output logic [7:0] out_chan3,
  output logic [2:0] out_channel_count,
  output logic [7:0] out_run_count
);

  logic       compressed_r;
  logic [2:0] bpp_r;
  logic [1:0] pixel_mode_r;
  logic [3:0] alpha_bits_r;

  logic       out_valid_r;
  trle_pkg::pixel_t pixel_r;
  logic [7:0] run_r;

  logic       accept;
  logic [2:0] eff_bpp;
  trle_pkg::emit_t      status;
  trle_pkg::pix_bytes_t pix_bytes;
  trle_pkg::pixel_t     pixel;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      compressed_r <= trle_pkg::RST_COMPRESSED;
      bpp_r        <= trle_pkg::RST_BYTES_PER_PIXEL;
      pixel_mode_r <= trle_pkg::RST_PIXEL_MODE;
      alpha_bits_r <= trle_pkg::RST_ALPHA_BITS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        trle_pkg::CFG_COMPRESSED:      compressed_r <= cfg_data[0];
        trle_pkg::CFG_BYTES_PER_PIXEL: bpp_r        <= cfg_data[2:0];
        trle_pkg::CFG_PIXEL_MODE:      pixel_mode_r <= cfg_data[1:0];
        trle_pkg::CFG_ALPHA_BITS:      alpha_bits_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Width zero behaves as one byte, widths above four as four.
  always_comb begin
    if (bpp_r == 3'd0) begin
      eff_bpp = 3'd1;
    end else if (bpp_r > 3'd4) begin
      eff_bpp = 3'd4;
    end else begin
      eff_bpp = bpp_r;
    end
  end

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  trle_packet_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .data_byte   (in_data_byte),
    .frame_start (in_frame_start),
    .compressed  (compressed_r),
    .eff_bpp     (eff_bpp),
    .status      (status),
    .pix_bytes   (pix_bytes)
  );

  trle_convert u_convert (
    .pix_bytes  (pix_bytes),
    .eff_bpp    (eff_bpp),
    .pixel_mode (pixel_mode_r),
    .alpha_bits (alpha_bits_r),
    .pixel      (pixel)
  );

  // Result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && status.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (accept && status.emit) begin
      pixel_r <= pixel;
      run_r   <= status.run;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_chan0         = pixel_r.chan0;
  assign out_chan1         = pixel_r.chan1;
  assign out_chan2         = pixel_r.chan2;
  assign out_chan3         = pixel_r.chan3;
  assign out_channel_count = pixel_r.channel_count;
  assign out_run_count     = run_r;

endmodule
